// ----- rtl/core/plbs_pkg.sv -----
`default_nettype none

package plbs_pkg;

    localparam int PALETTE_SIZE = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int NUM_REGS     = 5;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;
    localparam int HOLD_W       = 16;
    localparam int WORD_W       = 24;
    localparam int SEG_W        = 6;

    localparam logic [SEG_W-1:0] SEG_LAST_BIT = SEG_W'(2 * WORD_W - 1);
    localparam logic [SEG_W-1:0] SEG_LATCH    = SEG_W'(2 * WORD_W);

    localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [2:0] REG_ONE_LOW   = 3'd1;
    localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [2:0] REG_LATCH     = 3'd4;

    localparam logic [HOLD_W-1:0] RST_ONE_HIGH  = 16'd40;
    localparam logic [HOLD_W-1:0] RST_ONE_LOW   = 16'd22;
    localparam logic [HOLD_W-1:0] RST_ZERO_HIGH = 16'd20;
    localparam logic [HOLD_W-1:0] RST_ZERO_LOW  = 16'd42;
    localparam logic [HOLD_W-1:0] RST_LATCH     = 16'd300;

    typedef struct packed {
        logic [2:0] color_index;
        logic       end_of_frame;
    } plbs_pixel_t;

    typedef struct packed {
        logic              line_level;
        logic [HOLD_W-1:0] hold_cycles;
        logic              segment_last;
    } plbs_segment_t;

    typedef struct packed {
        logic [WORD_W-1:0] grb;
        logic              eof;
    } plbs_entry_t;

    typedef struct packed {
        logic [HOLD_W-1:0] one_high;
        logic [HOLD_W-1:0] one_low;
        logic [HOLD_W-1:0] zero_high;
        logic [HOLD_W-1:0] zero_low;
        logic [HOLD_W-1:0] latch;
    } plbs_timing_t;

    function automatic logic [WORD_W-1:0] palette_grb(input logic [2:0] idx);
        logic [WORD_W-1:0] grb;
        case (idx)
            3'd0:    grb = {8'd0,   8'd0,   8'd140};
            3'd1:    grb = {8'd116, 8'd0,   8'd64};
            3'd2:    grb = {8'd136, 8'd0,   8'd0};
            3'd3:    grb = {8'd140, 8'd140, 8'd0};
            3'd4:    grb = {8'd60,  8'd172, 8'd0};
            3'd5:    grb = {8'd0,   8'd120, 8'd0};
            3'd6:    grb = {8'd0,   8'd120, 8'd60};
            3'd7:    grb = {8'd40,  8'd120, 8'd160};
            default: grb = '0;
        endcase
        if (int'(idx) >= PALETTE_SIZE)
        begin
            grb = '0;
        end
        return grb;
    endfunction

    function automatic logic [HOLD_W-1:0] sat_hold(input logic [HOLD_W-1:0] r);
        return (r == '0) ? HOLD_W'(1) : r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/plbs_front.sv -----
`default_nettype none

module plbs_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    output logic                  full,
    input  plbs_pkg::plbs_pixel_t pixel,
    output logic                  q_push,
    output plbs_pkg::plbs_entry_t q_entry,
    input  wire                   q_ready
);
    import plbs_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    plbs_entry_t entry_reg;
    logic        accept;

    assign full    = valid_reg && !q_ready;
    assign accept  = push && !full;
    assign q_push  = valid_reg && q_ready;
    assign q_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg.grb <= palette_grb(pixel.color_index);
            entry_reg.eof <= pixel.end_of_frame;
        end
    end

    a_full_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> valid_reg)
        else $error("full without a held item");

endmodule

`default_nettype wire

// ----- rtl/core/plbs_queue.sv -----
`default_nettype none

module plbs_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   wr_en,
    input  plbs_pkg::plbs_entry_t wr_entry,
    output logic                  wr_ready,
    input  wire                   rd_en,
    output plbs_pkg::plbs_entry_t rd_entry,
    output logic                  rd_valid
);
    import plbs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    plbs_entry_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH)) || rd_en;
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue overfilled");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/core/plbs_back.sv -----
`default_nettype none

module plbs_back (
    input  wire                     clk,
    input  wire                     rst_n,
    input  plbs_pkg::plbs_timing_t  timing,
    input  wire                     q_valid,
    input  plbs_pkg::plbs_entry_t   q_entry,
    output logic                    q_pop,
    output logic                    empty,
    input  wire                     pop,
    output plbs_pkg::plbs_segment_t segment
);
    import plbs_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              eof_reg;
    logic              eof_next;
    logic [SEG_W-1:0]  seg_reg;
    logic [SEG_W-1:0]  seg_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    plbs_segment_t     out_reg;
    plbs_segment_t     out_next;

    logic              advance;
    logic              emit;
    logic [WORD_W-1:0] cur_word;
    logic              cur_eof;
    logic [SEG_W-1:0]  cur_seg;
    logic              cur_bit;
    logic              cur_last;

    assign advance  = !out_valid_reg || pop;
    assign emit     = advance && (busy_reg || q_valid);
    assign q_pop    = advance && !busy_reg && q_valid;
    assign cur_word = busy_reg ? word_reg : q_entry.grb;
    assign cur_eof  = busy_reg ? eof_reg : q_entry.eof;
    assign cur_seg  = busy_reg ? seg_reg : '0;
    assign cur_bit  = cur_word[WORD_W-1];
    assign cur_last = (cur_seg == SEG_LATCH) || ((cur_seg == SEG_LAST_BIT) && !cur_eof);

    assign empty   = !out_valid_reg;
    assign segment = out_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        word_next      = word_reg;
        eof_next       = eof_reg;
        seg_next       = seg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (emit)
        begin
            out_valid_next        = 1'b1;
            out_next.segment_last = cur_last;
            if (cur_seg == SEG_LATCH)
            begin
                out_next.line_level  = 1'b0;
                out_next.hold_cycles = sat_hold(timing.latch);
            end
            else if (!cur_seg[0])
            begin
                out_next.line_level  = 1'b1;
                out_next.hold_cycles = sat_hold(cur_bit ? timing.one_high : timing.zero_high);
            end
            else
            begin
                out_next.line_level  = 1'b0;
                out_next.hold_cycles = sat_hold(cur_bit ? timing.one_low : timing.zero_low);
            end
            word_next = cur_seg[0] ? {cur_word[WORD_W-2:0], 1'b0} : cur_word;
            eof_next  = cur_eof;
            seg_next  = cur_seg + 1'b1;
            busy_next = !cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        eof_reg  <= eof_next;
        out_reg  <= out_next;
    end

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((seg_reg < SEG_LATCH) || ((seg_reg == SEG_LATCH) && eof_reg)))
        else $error("segment count out of range");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cur_last) |=> (!busy_reg && out_valid_reg && out_reg.segment_last))
        else $error("final beat did not close the pixel");

endmodule

`default_nettype wire

// ----- rtl/core/palette_led_bit_serializer.sv -----
// Channel    Handshake          Payload
// pixel      push / full        color_index[2:0], end_of_frame
// segment    empty / pop        line_level, hold_cycles[15:0], segment_last
// config     APB psel/penable   five 16-bit timing registers at 4*i
//
// Each pixel yields 48 beats, 49 with end_of_frame; the back serializer
// emits one beat per cycle while pop keeps the segment register free.
// A pixel goes through the front stage and the queue to the output register.
// Reset (rst_n low, asynchronous) empties all stages and loads timing defaults.
// Output stall holds the segment register; the front stage and two-entry
// queue keep accepting until they fill, then full rises.
`default_nettype none

module palette_led_bit_serializer (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  push,
    output logic                                 full,
    input  plbs_pkg::plbs_pixel_t                pixel,
    output logic                                 empty,
    input  wire                                  pop,
    output plbs_pkg::plbs_segment_t              segment,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [plbs_pkg::PADDR_W-1:0]          paddr,
    input  wire [plbs_pkg::PDATA_W-1:0]          pwdata,
    output logic [plbs_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import plbs_pkg::*;

    plbs_timing_t timing_reg;
    plbs_timing_t timing_next;
    logic         wr_en;
    logic [2:0]   reg_idx;

    logic         fq_push;
    plbs_entry_t  fq_entry;
    logic         fq_ready;
    logic         qb_pop;
    plbs_entry_t  qb_entry;
    logic         qb_valid;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        timing_next = timing_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ONE_HIGH:  timing_next.one_high  = pwdata[HOLD_W-1:0];
                REG_ONE_LOW:   timing_next.one_low   = pwdata[HOLD_W-1:0];
                REG_ZERO_HIGH: timing_next.zero_high = pwdata[HOLD_W-1:0];
                REG_ZERO_LOW:  timing_next.zero_low  = pwdata[HOLD_W-1:0];
                REG_LATCH:     timing_next.latch     = pwdata[HOLD_W-1:0];
                default:       timing_next = timing_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ONE_HIGH:  prdata = PDATA_W'(timing_reg.one_high);
            REG_ONE_LOW:   prdata = PDATA_W'(timing_reg.one_low);
            REG_ZERO_HIGH: prdata = PDATA_W'(timing_reg.zero_high);
            REG_ZERO_LOW:  prdata = PDATA_W'(timing_reg.zero_low);
            REG_LATCH:     prdata = PDATA_W'(timing_reg.latch);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.one_high  <= RST_ONE_HIGH;
            timing_reg.one_low   <= RST_ONE_LOW;
            timing_reg.zero_high <= RST_ZERO_HIGH;
            timing_reg.zero_low  <= RST_ZERO_LOW;
            timing_reg.latch     <= RST_LATCH;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    plbs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .q_push  (fq_push),
        .q_entry (fq_entry),
        .q_ready (fq_ready)
    );

    plbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fq_push),
        .wr_entry (fq_entry),
        .wr_ready (fq_ready),
        .rd_en    (qb_pop),
        .rd_entry (qb_entry),
        .rd_valid (qb_valid)
    );

    plbs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .timing  (timing_reg),
        .q_valid (qb_valid),
        .q_entry (qb_entry),
        .q_pop   (qb_pop),
        .empty   (empty),
        .pop     (pop),
        .segment (segment)
    );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import plbs_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          push     = 1'b0;
    logic          full;
    plbs_pixel_t   pixel_in = '0;
    logic          empty;
    logic          pop      = 1'b0;
    plbs_segment_t segment_out;
    logic          psel     = 1'b0;
    logic          penable  = 1'b0;
    logic          pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr  = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic          pready;

    palette_led_bit_serializer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pixel   (pixel_in),
        .empty   (empty),
        .pop     (pop),
        .segment (segment_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    plbs_pixel_t   pending_pixels[$];
    plbs_segment_t expected_segments[$];
    plbs_timing_t  timing_now;

    logic pixel_taken   = 1'b0;
    logic sender_hold   = 1'b0;
    int   burst_left    = 1;
    int   gap_left      = 0;
    int   gap_max       = 0;
    int   stall_left    = 0;
    int   stall_pct     = 0;
    int   stall_max     = 1;
    int   idle_cycles   = 0;
    int   mismatch_count = 0;
    int   pixels_sent   = 0;
    int   frames_sent   = 0;
    int   segments_seen = 0;
    int   reg_writes    = 0;
    int   settings_used = 1;

    function automatic logic [HOLD_W-1:0] min_one_hold(input logic [HOLD_W-1:0] r);
        return (r == '0) ? HOLD_W'(1) : r;
    endfunction

    // green, red, blue bytes in send order
    function automatic logic [23:0] grb_for_index(input logic [2:0] idx);
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        case (idx)
            3'd0:    {red, green, blue} = {8'd0,   8'd0,   8'd140};
            3'd1:    {red, green, blue} = {8'd0,   8'd116, 8'd64};
            3'd2:    {red, green, blue} = {8'd0,   8'd136, 8'd0};
            3'd3:    {red, green, blue} = {8'd140, 8'd140, 8'd0};
            3'd4:    {red, green, blue} = {8'd172, 8'd60,  8'd0};
            3'd5:    {red, green, blue} = {8'd120, 8'd0,   8'd0};
            3'd6:    {red, green, blue} = {8'd120, 8'd0,   8'd60};
            default: {red, green, blue} = {8'd120, 8'd40,  8'd160};
        endcase
        if (int'(idx) >= PALETTE_SIZE)
        begin
            {red, green, blue} = '0;
        end
        return {green, red, blue};
    endfunction

    function automatic void predict_pixel(input plbs_pixel_t px);
        logic [23:0]   grb;
        plbs_segment_t seg;
        grb = grb_for_index(px.color_index);
        for (int i = 23; i >= 0; i--)
        begin
            seg.line_level   = 1'b1;
            seg.hold_cycles  = min_one_hold(grb[i] ? timing_now.one_high : timing_now.zero_high);
            seg.segment_last = 1'b0;
            expected_segments.push_back(seg);
            seg.line_level   = 1'b0;
            seg.hold_cycles  = min_one_hold(grb[i] ? timing_now.one_low : timing_now.zero_low);
            seg.segment_last = (i == 0) && !px.end_of_frame;
            expected_segments.push_back(seg);
        end
        if (px.end_of_frame)
        begin
            seg.line_level   = 1'b0;
            seg.hold_cycles  = min_one_hold(timing_now.latch);
            seg.segment_last = 1'b1;
            expected_segments.push_back(seg);
        end
    endfunction

    function automatic void note_mismatch(input string what, input plbs_segment_t want,
                                          input plbs_segment_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
        begin
            $display("[%0t] %s: expected level %0b hold %0d last %0b, got level %0b hold %0d last %0b",
                     $realtime, what, want.line_level, want.hold_cycles, want.segment_last,
                     got.line_level, got.hold_cycles, got.segment_last);
        end
    endfunction

    // driver: bursts of pixels with random gaps; hold push until the pixel is taken
    always @(negedge clk)
    begin
        logic        next_push;
        plbs_pixel_t next_pixel;
        next_push  = push;
        next_pixel = pixel_in;
        if (pixel_taken)
        begin
            void'(pending_pixels.pop_front());
            next_push = 1'b0;
        end
        if (!next_push)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else if (rst_n && !sender_hold && pending_pixels.size() != 0)
            begin
                next_push  = 1'b1;
                next_pixel = pending_pixels[0];
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = $urandom_range(0, gap_max);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
        push     <= next_push;
        pixel_in <= next_pixel;
    end

    // receiver: stall pattern of its own
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, stall_max);
            end
            pop <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        plbs_segment_t want;
        pixel_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
        begin
            predict_pixel(pixel_in);
            pixels_sent++;
            if (pixel_in.end_of_frame)
            begin
                frames_sent++;
            end
        end
        if (rst_n && pop && !empty)
        begin
            segments_seen++;
            if (expected_segments.size() == 0)
            begin
                note_mismatch("unexpected beat", '0, segment_out);
            end
            else
            begin
                want = expected_segments.pop_front();
                if (segment_out.line_level !== want.line_level
                    || segment_out.hold_cycles !== want.hold_cycles
                    || segment_out.segment_last !== want.segment_last)
                begin
                    note_mismatch("segment mismatch", want, segment_out);
                end
            end
        end
        if ((push && !full) || (pop && !empty))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles with no beat", STALL_LIMIT);
                $display("palette_led_bit_serializer: mismatch");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [2:0] reg_id, input logic [HOLD_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        case (reg_id)
            REG_ONE_HIGH:  timing_now.one_high  = value;
            REG_ONE_LOW:   timing_now.one_low   = value;
            REG_ZERO_HIGH: timing_now.zero_high = value;
            REG_ZERO_LOW:  timing_now.zero_low  = value;
            REG_LATCH:     timing_now.latch     = value;
            default:       ;
        endcase
    endtask

    task automatic load_timing(input logic [HOLD_W-1:0] one_high, input logic [HOLD_W-1:0] one_low,
                               input logic [HOLD_W-1:0] zero_high,
                               input logic [HOLD_W-1:0] zero_low,
                               input logic [HOLD_W-1:0] latch);
        apb_write(REG_ONE_HIGH, one_high);
        apb_write(REG_ONE_LOW, one_low);
        apb_write(REG_ZERO_HIGH, zero_high);
        apb_write(REG_ZERO_LOW, zero_low);
        apb_write(REG_LATCH, latch);
        settings_used++;
    endtask

    task automatic drain_all();
        while (pending_pixels.size() != 0 || push || expected_segments.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic queue_random_pixels(input int count);
        plbs_pixel_t px;
        for (int i = 0; i < count; i++)
        begin
            px.color_index  = 3'($urandom_range(0, 7));
            px.end_of_frame = ($urandom_range(0, 7) == 0);
            pending_pixels.push_back(px);
        end
    endtask

    function automatic logic [HOLD_W-1:0] random_hold();
        case ($urandom_range(0, 3))
            0:       return HOLD_W'($urandom_range(1, 100));
            1:       return HOLD_W'($urandom_range(0, 3));
            default: return HOLD_W'($urandom());
        endcase
    endfunction

    initial
    begin
        plbs_pixel_t px;
        timing_now = '{RST_ONE_HIGH, RST_ONE_LOW, RST_ZERO_HIGH, RST_ZERO_LOW, RST_LATCH};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset timing: every palette entry with and without frame end
        for (int e = 0; e < 2; e++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                px.color_index  = 3'(c);
                px.end_of_frame = e[0];
                pending_pixels.push_back(px);
            end
        end
        drain_all();

        // zero registers saturate to a hold_cycles value of one
        load_timing('0, '0, '0, '0, '0);
        stall_pct = 30;
        stall_max = 4;
        gap_max   = 20;
        for (int c = 0; c < 8; c++)
        begin
            px.color_index  = 3'(c);
            px.end_of_frame = c[0];
            pending_pixels.push_back(px);
        end
        drain_all();

        // writes outside the register map change nothing; all five registers are then reloaded
        for (int r = NUM_REGS; r < 8; r++)
        begin
            apb_write(3'(r), HOLD_W'($urandom()));
        end
        load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random_pixels(40);
        drain_all();

        load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        stall_pct = 0;
        gap_max   = 0;
        queue_random_pixels(30);
        // pause the sender until the block runs dry, then resume
        while (pending_pixels.size() > 15)
        begin
            @(negedge clk);
        end
        sender_hold = 1'b1;
        while (push || expected_segments.size() != 0)
        begin
            @(negedge clk);
        end
        sender_hold = 1'b0;
        drain_all();

        for (int p = 0; p < 6; p++)
        begin
            load_timing(random_hold(), random_hold(), random_hold(), random_hold(), random_hold());
            stall_pct = (p % 3) * 30;
            stall_max = (p < 3) ? 3 : 25;
            gap_max   = (p % 2) ? 80 : 5;
            queue_random_pixels(60);
            drain_all();
        end

        repeat (60) @(negedge clk);
        while (expected_segments.size() != 0)
        begin
            note_mismatch("missing beat", expected_segments.pop_front(), '0);
        end
        $display("run covered %0d pixels (%0d ending a frame) and %0d segments",
                 pixels_sent, frames_sent, segments_seen);
        $display("with %0d register writes across %0d timing settings, %0d mismatches",
                 reg_writes, settings_used, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("palette_led_bit_serializer: match");
        end
        else
        begin
            $display("palette_led_bit_serializer: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/plbs_pkg.sv
rtl/core/plbs_front.sv
rtl/core/plbs_queue.sv
rtl/core/plbs_back.sv
rtl/core/palette_led_bit_serializer.sv
sim/tb_top.sv
